// ===== rtl/mcpg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mcpg_pkg;

    localparam int IN_COORD_BITS      = 13;
    localparam int RADIUS_BITS        = 12;
    localparam int OUT_BITS           = 14;
    localparam int DEC_BITS           = 16;
    localparam int PT_BITS            = 5;
    localparam int COORD_BITS_DEFAULT = 13;
    localparam int BEATS              = 8;
    localparam int BEAT_IDX_BITS      = $clog2(BEATS);
    localparam int S_TDATA_BITS       = 40;
    localparam int M_TDATA_BITS       = 32;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [PT_BITS-1:0] PT_RESET = PT_BITS'(1);

    typedef struct packed {
        logic load;
        logic done;
    } emit_ctrl_t;

    typedef struct packed {
        logic can_load;
        logic busy;
    } emit_stat_t;

endpackage
`default_nettype wire

// ===== rtl/mcpg_emitter.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mcpg_emitter #(
    parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEFAULT
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  mcpg_pkg::emit_ctrl_t                 ctrl,
    input  wire  signed [COORD_BITS-1:0]         cx_next,
    input  wire  signed [COORD_BITS-1:0]         cy_next,
    input  wire  signed [COORD_BITS-1:0]         a_next,
    input  wire  signed [COORD_BITS-1:0]         b_next,
    output mcpg_pkg::emit_stat_t                 stat,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic signed [mcpg_pkg::OUT_BITS-1:0] point_x,
    output logic signed [mcpg_pkg::OUT_BITS-1:0] point_y,
    output logic                                 out_last,
    output logic                                 out_done
);

    localparam int LW = (COORD_BITS + 1 > mcpg_pkg::OUT_BITS) ?
                        COORD_BITS + 1 : mcpg_pkg::OUT_BITS;
    localparam logic [mcpg_pkg::BEAT_IDX_BITS-1:0] LAST_IDX =
        mcpg_pkg::BEAT_IDX_BITS'(mcpg_pkg::BEATS - 1);

    logic signed [COORD_BITS-1:0] cx_reg, cy_reg, a_reg, b_reg;
    logic                         done_reg;
    logic                         busy_reg;
    logic [mcpg_pkg::BEAT_IDX_BITS-1:0] idx_reg;

    logic                 last_beat;
    logic                 beat_taken;
    logic signed [COORD_BITS-1:0] u, v;
    logic signed [LW-1:0] sum_x, sum_y;

    assign last_beat  = (idx_reg == LAST_IDX);
    assign beat_taken = busy_reg && out_ready;

    assign stat.busy     = busy_reg;
    assign stat.can_load = !busy_reg || (beat_taken && last_beat);

    // The low half mirrors (a, b), the high half swaps the roles of a and b.
    always_comb begin
        u = idx_reg[2] ? b_reg : a_reg;
        v = idx_reg[2] ? a_reg : b_reg;
        if (idx_reg[1]) begin
            sum_x = LW'(cx_reg) - LW'(u);
        end else begin
            sum_x = LW'(cx_reg) + LW'(u);
        end
        if (idx_reg[0]) begin
            sum_y = LW'(cy_reg) - LW'(v);
        end else begin
            sum_y = LW'(cy_reg) + LW'(v);
        end
    end

    assign out_valid = busy_reg;
    assign point_x   = $signed(sum_x[mcpg_pkg::OUT_BITS-1:0]);
    assign point_y   = $signed(sum_y[mcpg_pkg::OUT_BITS-1:0]);
    assign out_last  = last_beat;
    assign out_done  = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (ctrl.load) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (beat_taken) begin
            if (last_beat) begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            done_reg <= ctrl.done;
        end
    end

    a_load_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load |=> busy_reg && idx_reg == '0)
        else $error("emitter did not start a run after load");

    a_stall_holds_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !out_ready && !ctrl.load) |=> $stable(idx_reg) && busy_reg)
        else $error("beat index moved during a stall");

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load |-> stat.can_load)
        else $error("emitter loaded while a run was still pending");

endmodule
`default_nettype wire

// ===== rtl/midpoint_circle_point_generator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake                 Payload
// s_       in   s_tvalid / s_tready       s_tdata, s_tuser (command)
// m_       out  m_tvalid / m_tready       m_tdata, m_tlast, m_tuser (done_res)
// cfg_     in   cfg_valid / cfg_ready     cfg_data (point_size)
//
// A start command, or a step while a circle is active, yields eight beats, one per cycle
// while m_tready stays high; the single result channel limits the sustained command rate.
// A step with no active circle leaves the input register as soon as a new run could start,
// and yields no beat.
// An input register takes the next command while the current run is still going out.
// Reset is synchronous on aresetn low; m_tready low holds the current beat.
module midpoint_circle_point_generator_core #(
    parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEFAULT
) (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    input  wire                                      s_tvalid,
    output logic                                     s_tready,
    // [12:0] center_x, [25:13] center_y, [37:26] radius, [39:38] zero
    input  wire  [mcpg_pkg::S_TDATA_BITS-1:0]        s_tdata,
    // [0] command
    input  wire                                      s_tuser,
    output logic                                     m_tvalid,
    input  wire                                      m_tready,
    // [13:0] point_x, [27:14] point_y, [31:28] zero
    output logic [mcpg_pkg::M_TDATA_BITS-1:0]        m_tdata,
    output logic                                     m_tlast,
    // [0] done_res
    output logic                                     m_tuser,
    input  wire                                      cfg_valid,
    output logic                                     cfg_ready,
    input  wire  [mcpg_pkg::PT_BITS-1:0]             cfg_data
);

    localparam int DB = mcpg_pkg::DEC_BITS;

    logic [mcpg_pkg::PT_BITS-1:0] point_size_reg;

    logic                                       in_vld_reg;
    logic                                       in_cmd_reg;
    logic signed [mcpg_pkg::IN_COORD_BITS-1:0]  in_cx_reg, in_cy_reg;
    logic [mcpg_pkg::RADIUS_BITS-1:0]           in_r_reg;

    logic signed [COORD_BITS-1:0] centre_x_reg, centre_y_reg;
    logic signed [COORD_BITS-1:0] offset_x_reg, offset_y_reg;
    logic [DB-1:0]                decision_reg, straight_reg, diagonal_reg;
    logic                         active_reg;

    logic signed [COORD_BITS-1:0] centre_x_next, centre_y_next;
    logic signed [COORD_BITS-1:0] offset_x_next, offset_y_next;
    logic [DB-1:0]                decision_next, straight_next, diagonal_next;
    logic                         fin_next;

    logic [mcpg_pkg::PT_BITS-1:0] pt;
    logic [DB-1:0]                pt_d;
    logic [DB-1:0]                r_d;
    logic [COORD_BITS-1:0]        pt_c;
    logic                         is_start;
    logic                         move;
    logic                         emits;

    mcpg_pkg::emit_ctrl_t ctrl;
    mcpg_pkg::emit_stat_t stat;

    logic signed [mcpg_pkg::OUT_BITS-1:0] point_x, point_y;

    assign cfg_ready = 1'b1;

    assign pt   = (point_size_reg == '0) ? mcpg_pkg::PT_BITS'(1) : point_size_reg;
    assign pt_d = DB'(pt);
    assign r_d  = DB'(in_r_reg);
    assign pt_c = COORD_BITS'(pt);

    assign is_start = (in_cmd_reg == mcpg_pkg::CMD_START);
    assign move     = in_vld_reg && stat.can_load;
    assign emits    = is_start || active_reg;
    assign s_tready = !in_vld_reg || move;

    always_comb begin
        centre_x_next = centre_x_reg;
        centre_y_next = centre_y_reg;
        offset_x_next = offset_x_reg;
        offset_y_next = offset_y_reg;
        decision_next = decision_reg;
        straight_next = straight_reg;
        diagonal_next = diagonal_reg;
        if (is_start) begin
            centre_x_next = COORD_BITS'(in_cx_reg);
            centre_y_next = COORD_BITS'(in_cy_reg);
            offset_x_next = '0;
            offset_y_next = COORD_BITS'(in_r_reg);
            decision_next = pt_d - r_d;
            straight_next = pt_d * DB'(3);
            diagonal_next = pt_d * DB'(5) - {r_d[DB-2:0], 1'b0};
        end else begin
            if (decision_reg[DB-1]) begin
                decision_next = decision_reg + straight_reg;
                diagonal_next = diagonal_reg + {pt_d[DB-2:0], 1'b0};
            end else begin
                decision_next = decision_reg + diagonal_reg;
                diagonal_next = diagonal_reg + {pt_d[DB-3:0], 2'b00};
                offset_y_next = offset_y_reg - pt_c;
            end
            straight_next = straight_reg + {pt_d[DB-2:0], 1'b0};
            offset_x_next = offset_x_reg + pt_c;
        end
        fin_next = (offset_y_next <= offset_x_next);
    end

    assign ctrl.load = move && emits;
    assign ctrl.done = fin_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_size_reg <= mcpg_pkg::PT_RESET;
            in_vld_reg     <= 1'b0;
            centre_x_reg   <= '0;
            centre_y_reg   <= '0;
            offset_x_reg   <= '0;
            offset_y_reg   <= '0;
            decision_reg   <= '0;
            straight_reg   <= '0;
            diagonal_reg   <= '0;
            active_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                point_size_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (move) begin
                in_vld_reg <= 1'b0;
            end
            if (move && emits) begin
                centre_x_reg <= centre_x_next;
                centre_y_reg <= centre_y_next;
                offset_x_reg <= offset_x_next;
                offset_y_reg <= offset_y_next;
                decision_reg <= decision_next;
                straight_reg <= straight_next;
                diagonal_reg <= diagonal_next;
                active_reg   <= !fin_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg <= s_tuser;
            in_cx_reg  <= $signed(s_tdata[12:0]);
            in_cy_reg  <= $signed(s_tdata[25:13]);
            in_r_reg   <= s_tdata[37:26];
        end
    end

    mcpg_emitter #(
        .COORD_BITS (COORD_BITS)
    ) u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .cx_next   (centre_x_next),
        .cy_next   (centre_y_next),
        .a_next    (offset_x_next),
        .b_next    (offset_y_next),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .point_x   (point_x),
        .point_y   (point_y),
        .out_last  (m_tlast),
        .out_done  (m_tuser)
    );

    assign m_tdata = {{(mcpg_pkg::M_TDATA_BITS - 2 * mcpg_pkg::OUT_BITS){1'b0}},
                      point_y, point_x};

    a_start_clears_x: assert property (@(posedge aclk) disable iff (!aresetn)
        (move && is_start) |=> offset_x_reg == '0)
        else $error("start command left a nonzero x offset");

    a_idle_step_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (move && !is_start && !active_reg) |=>
            $stable(offset_x_reg) && $stable(offset_y_reg) && $stable(decision_reg))
        else $error("step without an active circle changed the state");

    a_active_means_open: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> offset_y_reg > offset_x_reg)
        else $error("circle marked active although the octant is finished");

    a_emit_loads_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (move && emits) |=> m_tvalid)
        else $error("emitting command produced no beat");

endmodule
`default_nettype wire

// ===== bench/mcpg_point_checker.sv =====
`timescale 1ns / 1ps
module mcpg_point_checker #(
    parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEFAULT
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    input  wire                                 s_tready,
    input  wire  [mcpg_pkg::S_TDATA_BITS-1:0]   s_tdata,
    input  wire                                 s_tuser,
    input  wire                                 m_tvalid,
    input  wire                                 m_tready,
    input  wire  [mcpg_pkg::M_TDATA_BITS-1:0]   m_tdata,
    input  wire                                 m_tlast,
    input  wire                                 m_tuser,
    input  wire                                 cfg_valid,
    input  wire                                 cfg_ready,
    input  wire  [mcpg_pkg::PT_BITS-1:0]        cfg_data,
    output int                                  mismatch_count,
    output int                                  pending_points,
    output logic                                circle_open
);

    localparam int OB  = mcpg_pkg::OUT_BITS;
    localparam int DB  = mcpg_pkg::DEC_BITS;
    localparam int ICB = mcpg_pkg::IN_COORD_BITS;
    localparam int RB  = mcpg_pkg::RADIUS_BITS;

    typedef struct packed {
        logic signed [OB-1:0] x;
        logic signed [OB-1:0] y;
        logic                 last;
        logic                 done;
    } plot_point_t;

    plot_point_t expected_points[$];

    logic [mcpg_pkg::PT_BITS-1:0] cell_size;
    logic signed [COORD_BITS-1:0] ctr_x;
    logic signed [COORD_BITS-1:0] ctr_y;
    logic signed [COORD_BITS-1:0] off_x;
    logic signed [COORD_BITS-1:0] off_y;
    logic signed [DB-1:0]         decision;
    logic signed [DB-1:0]         straight_inc;
    logic signed [DB-1:0]         diag_inc;
    logic                         running;

    // The eight mirrored points of the current offset, in octant order.
    task automatic queue_octant_points();
        logic signed [OB-1:0] cx;
        logic signed [OB-1:0] cy;
        logic signed [OB-1:0] a;
        logic signed [OB-1:0] b;
        logic signed [OB-1:0] along;
        logic signed [OB-1:0] across;
        logic                 fin;
        plot_point_t          pt;
        cx = OB'(ctr_x);
        cy = OB'(ctr_y);
        a = OB'(off_x);
        b = OB'(off_y);
        fin = (off_y <= off_x);
        running = !fin;
        for (int k = 0; k < mcpg_pkg::BEATS; k++) begin
            along = (k < 4) ? a : b;
            across = (k < 4) ? b : a;
            pt.x = k[1] ? (cx - along) : (cx + along);
            pt.y = k[0] ? (cy - across) : (cy + across);
            pt.last = (k == mcpg_pkg::BEATS - 1);
            pt.done = fin;
            expected_points.push_back(pt);
        end
    endtask

    always @(posedge aclk) begin
        plot_point_t   want;
        plot_point_t   got;
        int            span;
        logic [RB-1:0] r;
        if (!aresetn) begin
            cell_size = mcpg_pkg::PT_RESET;
            ctr_x = '0;
            ctr_y = '0;
            off_x = '0;
            off_y = '0;
            decision = '0;
            straight_inc = '0;
            diag_inc = '0;
            running = 1'b0;
            expected_points.delete();
            mismatch_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.x = m_tdata[OB-1:0];
                got.y = m_tdata[2*OB-1:OB];
                got.last = m_tlast;
                got.done = m_tuser;
                if (expected_points.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: unexpected beat x=%0d y=%0d last=%0b done=%0b",
                                 $time, got.x, got.y, got.last, got.done);
                    end
                end else begin
                    want = expected_points.pop_front();
                    if (got != want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display({"%0t: expected x=%0d y=%0d last=%0b done=%0b, ",
                                      "got x=%0d y=%0d last=%0b done=%0b"},
                                     $time, want.x, want.y, want.last, want.done,
                                     got.x, got.y, got.last, got.done);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                cell_size = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                span = (cell_size == 0) ? 1 : int'(cell_size);
                if (s_tuser == mcpg_pkg::CMD_START) begin
                    r = s_tdata[2*ICB+RB-1:2*ICB];
                    ctr_x = COORD_BITS'($signed(s_tdata[ICB-1:0]));
                    ctr_y = COORD_BITS'($signed(s_tdata[2*ICB-1:ICB]));
                    off_x = '0;
                    off_y = COORD_BITS'(r);
                    decision = DB'(span - int'(r));
                    straight_inc = DB'(3 * span);
                    diag_inc = DB'(5 * span - 2 * int'(r));
                    queue_octant_points();
                end else if (running) begin
                    if (decision < 0) begin
                        decision = decision + straight_inc;
                        diag_inc = diag_inc + DB'(2 * span);
                    end else begin
                        decision = decision + diag_inc;
                        diag_inc = diag_inc + DB'(4 * span);
                        off_y = off_y - COORD_BITS'(span);
                    end
                    straight_inc = straight_inc + DB'(2 * span);
                    off_x = off_x + COORD_BITS'(span);
                    queue_octant_points();
                end
            end
        end
        pending_points = expected_points.size();
        circle_open = running;
    end

endmodule

// ===== bench/midpoint_circle_point_generator_core_test.sv =====
`timescale 1ns / 1ps
module midpoint_circle_point_generator_core_test;

    localparam int COORD_BITS = mcpg_pkg::COORD_BITS_DEFAULT;
    localparam int ICB        = mcpg_pkg::IN_COORD_BITS;
    localparam int RB         = mcpg_pkg::RADIUS_BITS;
    localparam int PB         = mcpg_pkg::PT_BITS;

    logic                                aclk;
    logic                                aresetn = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [mcpg_pkg::S_TDATA_BITS-1:0]   s_tdata = '0;
    logic                                s_tuser = mcpg_pkg::CMD_START;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [mcpg_pkg::M_TDATA_BITS-1:0]   m_tdata;
    logic                                m_tlast;
    logic                                m_tuser;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [PB-1:0]                       cfg_data = mcpg_pkg::PT_RESET;

    int                                  mismatch_count;
    int                                  pending_points;
    logic                                circle_open;

    logic                                quiet = 1'b0;
    logic [PB-1:0]                       cur_pt = mcpg_pkg::PT_RESET;
    int                                  counted = 0;

    midpoint_circle_point_generator_core #(
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    mcpg_point_checker #(
        .COORD_BITS(COORD_BITS)
    ) u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_points (pending_points),
        .circle_open    (circle_open)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 38);
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_item(input logic cmd, input logic [ICB-1:0] cx,
                             input logic [ICB-1:0] cy,
                             input logic [RB-1:0] r);
        while (!quiet && $urandom_range(0, 99) < 38) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b00, r, cy, cx};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_point_size(input logic [PB-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_points != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cur_pt = value;
    endtask

    task automatic run_circle(input logic [ICB-1:0] cx,
                              input logic [ICB-1:0] cy,
                              input logic [RB-1:0] r, input int max_steps);
        int n;
        send_item(mcpg_pkg::CMD_START, cx, cy, r);
        counted++;
        for (n = 0; n < max_steps && circle_open; n++) begin
            send_item(mcpg_pkg::CMD_STEP, ICB'($urandom), ICB'($urandom), RB'($urandom));
            counted++;
        end
    endtask

    initial begin
        int               phase;
        int               kind;
        int               reach;
        int               span;
        logic             cmd;
        logic [PB-1:0]    next_pt;
        phase = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // A zero radius finishes at once, so the following step is dropped.
        run_circle(13'd0, 13'd0, 12'd0, 0);
        send_item(mcpg_pkg::CMD_STEP, 13'd0, 13'd0, 12'd0);
        run_circle(13'h1000, 13'h0fff, 12'hfff, 2);
        run_circle(13'h0fff, 13'h1000, 12'd1, 4);
        send_item(mcpg_pkg::CMD_STEP, 13'h1fff, 13'h1fff, 12'hfff);
        run_circle(13'd5, -13'sd7, 12'd6, 20);

        // A cell size of zero behaves as one.
        write_point_size(5'd0);
        run_circle(13'd100, -13'sd100, 12'd3, 20);
        write_point_size(5'd31);
        run_circle(13'h0fff, 13'h0fff, 12'hfff, 3);
        run_circle(13'h1000, 13'h1000, 12'd5, 4);
        write_point_size(5'd16);
        run_circle(-13'sd300, 13'd250, 12'd40, 20);

        counted = 0;
        while (counted < 260) begin
            if (counted >= phase * 45) begin
                phase++;
                case ($urandom_range(0, 5))
                    0: next_pt = 5'd1;
                    1: next_pt = 5'd16;
                    2: next_pt = 5'd31;
                    3: next_pt = 5'd0;
                    default: next_pt = PB'($urandom_range(1, 31));
                endcase
                write_point_size(next_pt);
            end
            quiet <= (counted >= 120 && counted < 175);
            span = (cur_pt == 0) ? 1 : int'(cur_pt);
            kind = int'($urandom_range(0, 99));
            if (kind < 10) begin
                cmd = 1'($urandom_range(0, 1));
                if (cmd == mcpg_pkg::CMD_START || circle_open) begin
                    counted++;
                end
                send_item(cmd, ICB'($urandom), ICB'($urandom), RB'($urandom));
            end else if (kind < 20) begin
                run_circle(ICB'($urandom), ICB'($urandom), RB'($urandom_range(0, 4095)),
                           int'($urandom_range(0, 6)));
            end else begin
                reach = (24 * span > 4095) ? 4095 : 24 * span;
                run_circle(ICB'($urandom), ICB'($urandom), RB'($urandom_range(0, reach)), 80);
                repeat ($urandom_range(0, 2)) begin
                    send_item(mcpg_pkg::CMD_STEP, ICB'($urandom), ICB'($urandom),
                              RB'($urandom));
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_points != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
        if (mismatch_count == 0 && pending_points == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mcpg_pkg.sv
rtl/mcpg_emitter.sv
rtl/midpoint_circle_point_generator_core.sv
bench/mcpg_point_checker.sv
bench/midpoint_circle_point_generator_core_test.sv
